### src/iafmt_pkg.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Shared types, codes and sizes for the formatter front end, queue and back end.
// ----------------------------------------------------------------------------
package iafmt_pkg;

  // Digit store: one 4-bit digit per slot, most significant digit in the top slot.
  localparam int DIGIT_SLOTS = 20;
  localparam int BUF_W       = DIGIT_SLOTS * 4;
  localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);

  // Decimal conversion of a 32-bit magnitude into ten BCD digits.
  localparam int BIN_W  = 32;
  localparam int BCD_W  = 40;
  localparam int STEP_W = $clog2(BIN_W);

  // Prefix text: up to five characters, first character in the top byte.
  localparam int PRE_W     = 40;
  localparam int PRE_CNT_W = 3;

  localparam int TOTAL_W     = 31;
  localparam int QUEUE_DEPTH = 2;

  // ASCII codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_L       = 8'h6C;
  localparam logic [7:0] CH_RPAREN  = 8'h29;

  typedef enum logic [2:0] {
    MODE_SDEC  = 3'd0,
    MODE_UDEC  = 3'd1,
    MODE_HEX_L = 3'd2,
    MODE_HEX_U = 3'd3,
    MODE_PTR   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    DIG_NONE,
    DIG_DEC,
    DIG_HEX32,
    DIG_HEX64
  } dig_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_PRE,
    ST_DIG
  } state_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] value;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         character;
    logic               last;
    logic [TOTAL_W-1:0] total_count;
  } out_word_t;

  // Classified job handed from the front end to the back end.
  typedef struct packed {
    dig_e                 dig;
    logic                 upper;
    logic [63:0]          mag;
    logic [PRE_CNT_W-1:0] pre_len;
    logic [PRE_W-1:0]     pre_text;
  } cmd_t;

  // Queue status seen by the two ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### src/iafmt_front.sv
// ----------------------------------------------------------------------------
// Formatter front end
// Holds the null pointer style register, accepts input words, decodes the mode
// into a prefix text and a digit job, and pushes the job into the queue.
// ----------------------------------------------------------------------------
module iafmt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  iafmt_pkg::in_word_t in_word_i,
  input  iafmt_pkg::q_status_t q_status_i,
  output logic                push_o,
  output iafmt_pkg::cmd_t     cmd_o
);

  logic        style_q;
  logic        style_d;
  logic        mode_ok;
  logic [31:0] low;
  logic [31:0] neg;

  assign style_d = cfg_we_i ? cfg_wdata_i : style_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q <= 1'b0;
    end else begin
      style_q <= style_d;
    end
  end

  assign low = in_word_i.value[31:0];
  assign neg = ~low + 32'd1;

  always_comb begin
    cmd_o          = '0;
    cmd_o.dig      = iafmt_pkg::DIG_NONE;
    mode_ok        = 1'b1;
    unique case (in_word_i.mode)
      iafmt_pkg::MODE_SDEC: begin
        cmd_o.dig = iafmt_pkg::DIG_DEC;
        if (low[31]) begin
          cmd_o.mag      = {32'd0, neg};
          cmd_o.pre_len  = iafmt_pkg::PRE_CNT_W'(1);
          cmd_o.pre_text = {iafmt_pkg::CH_MINUS, 32'd0};
        end else begin
          cmd_o.mag = {32'd0, low};
        end
      end
      iafmt_pkg::MODE_UDEC: begin
        cmd_o.dig = iafmt_pkg::DIG_DEC;
        cmd_o.mag = {32'd0, low};
      end
      iafmt_pkg::MODE_HEX_L,
      iafmt_pkg::MODE_HEX_U: begin
        cmd_o.dig   = iafmt_pkg::DIG_HEX32;
        cmd_o.mag   = {32'd0, low};
        cmd_o.upper = (in_word_i.mode == iafmt_pkg::MODE_HEX_U);
      end
      iafmt_pkg::MODE_PTR: begin
        if (in_word_i.value == 64'd0) begin
          if (style_q) begin
            cmd_o.pre_len  = iafmt_pkg::PRE_CNT_W'(3);
            cmd_o.pre_text = {iafmt_pkg::CH_ZERO, iafmt_pkg::CH_X, iafmt_pkg::CH_ZERO,
                              16'd0};
          end else begin
            cmd_o.pre_len  = iafmt_pkg::PRE_CNT_W'(5);
            cmd_o.pre_text = {iafmt_pkg::CH_LPAREN, iafmt_pkg::CH_N, iafmt_pkg::CH_I,
                              iafmt_pkg::CH_L, iafmt_pkg::CH_RPAREN};
          end
        end else begin
          cmd_o.dig      = iafmt_pkg::DIG_HEX64;
          cmd_o.mag      = in_word_i.value;
          cmd_o.pre_len  = iafmt_pkg::PRE_CNT_W'(2);
          cmd_o.pre_text = {iafmt_pkg::CH_ZERO, iafmt_pkg::CH_X, 24'd0};
        end
      end
      default: begin
        // Unused modes print nothing and are simply consumed.
        mode_ok = 1'b0;
      end
    endcase
  end

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full && mode_ok;

endmodule

### src/iafmt_queue.sv
// ----------------------------------------------------------------------------
// Formatter job queue
// Short first-in first-out buffer of decoded jobs between front and back end.
// ----------------------------------------------------------------------------
module iafmt_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  iafmt_pkg::cmd_t      push_cmd_i,
  input  logic                 pop_i,
  output iafmt_pkg::cmd_t      head_o,
  output iafmt_pkg::q_status_t status_o
);

  localparam int PTR_W = (iafmt_pkg::QUEUE_DEPTH > 1) ? $clog2(iafmt_pkg::QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(iafmt_pkg::QUEUE_DEPTH + 1);

  iafmt_pkg::cmd_t mem_q [iafmt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(iafmt_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign status_o.full  = (count_q == QCNT_W'(iafmt_pkg::QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### src/iafmt_back.sv
// ----------------------------------------------------------------------------
// Formatter back end
// Takes decoded jobs from the queue, converts decimal magnitudes to BCD by
// shift-and-add-three, drops leading zero digits and, unless stalled, emits one
// character per cycle via a registered output stage with saturating character total.
// ----------------------------------------------------------------------------
module iafmt_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iafmt_pkg::q_status_t q_status_i,
  input  iafmt_pkg::cmd_t      head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output iafmt_pkg::out_word_t out_word_o
);

  iafmt_pkg::state_e               state_q, state_d;
  logic [iafmt_pkg::PRE_W-1:0]     pre_q, pre_d;
  logic [iafmt_pkg::PRE_CNT_W-1:0] pre_cnt_q, pre_cnt_d;
  logic                            upper_q, upper_d;
  logic [iafmt_pkg::BUF_W-1:0]     buf_q, buf_d;
  logic [iafmt_pkg::CNT_W-1:0]     nd_q, nd_d;
  logic [iafmt_pkg::BIN_W-1:0]     bin_q, bin_d;
  logic [iafmt_pkg::BCD_W-1:0]     bcd_q, bcd_d;
  logic [iafmt_pkg::STEP_W-1:0]    step_q, step_d;
  logic [iafmt_pkg::TOTAL_W-1:0]   total_q, total_d;
  iafmt_pkg::out_word_t            out_q, out_d;
  logic                            out_valid_q, out_valid_d;

  logic                            can_put;
  logic [3:0]                      top_dig;
  logic [7:0]                      dig_char;
  logic [iafmt_pkg::TOTAL_W-1:0]   total_inc;
  logic [iafmt_pkg::BCD_W-1:0]     bcd_adj;

  // Add three to every BCD digit of five or more before the next shift.
  function automatic logic [iafmt_pkg::BCD_W-1:0] bcd_add3(
    input logic [iafmt_pkg::BCD_W-1:0] v
  );
    logic [iafmt_pkg::BCD_W-1:0] r;
    r = v;
    for (int i = 0; i < iafmt_pkg::BCD_W / 4; i++) begin
      if (v[i*4 +: 4] >= 4'd5) begin
        r[i*4 +: 4] = v[i*4 +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  assign can_put   = !out_valid_q || !out_stall_i;
  assign top_dig   = buf_q[iafmt_pkg::BUF_W-1 -: 4];
  assign total_inc = (total_q == '1) ? total_q : total_q + iafmt_pkg::TOTAL_W'(1);
  assign bcd_adj   = bcd_add3(bcd_q);

  always_comb begin
    if (top_dig < 4'd10) begin
      dig_char = iafmt_pkg::CH_ZERO + {4'd0, top_dig};
    end else if (upper_q) begin
      dig_char = iafmt_pkg::CH_UPPER_A + {4'd0, top_dig} - 8'd10;
    end else begin
      dig_char = iafmt_pkg::CH_LOWER_A + {4'd0, top_dig} - 8'd10;
    end
  end

  always_comb begin
    state_d     = state_q;
    pre_d       = pre_q;
    pre_cnt_d   = pre_cnt_q;
    upper_d     = upper_q;
    buf_d       = buf_q;
    nd_d        = nd_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    step_d      = step_q;
    total_d     = total_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;

    unique case (state_q)
      iafmt_pkg::ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o     = 1'b1;
          pre_d     = head_i.pre_text;
          pre_cnt_d = head_i.pre_len;
          upper_d   = head_i.upper;
          bin_d     = head_i.mag[iafmt_pkg::BIN_W-1:0];
          bcd_d     = '0;
          step_d    = '0;
          state_d   = iafmt_pkg::ST_SKIP;
          unique case (head_i.dig)
            iafmt_pkg::DIG_DEC: begin
              nd_d    = '0;
              state_d = iafmt_pkg::ST_CONV;
            end
            iafmt_pkg::DIG_HEX32: begin
              buf_d = {head_i.mag[31:0], {(iafmt_pkg::BUF_W - 32){1'b0}}};
              nd_d  = iafmt_pkg::CNT_W'(8);
            end
            iafmt_pkg::DIG_HEX64: begin
              buf_d = {head_i.mag, {(iafmt_pkg::BUF_W - 64){1'b0}}};
              nd_d  = iafmt_pkg::CNT_W'(16);
            end
            default: begin
              nd_d = '0;
            end
          endcase
        end
      end
      iafmt_pkg::ST_CONV: begin
        bcd_d  = {bcd_adj[iafmt_pkg::BCD_W-2:0], bin_q[iafmt_pkg::BIN_W-1]};
        bin_d  = {bin_q[iafmt_pkg::BIN_W-2:0], 1'b0};
        step_d = step_q + iafmt_pkg::STEP_W'(1);
        if (step_q == '1) begin
          buf_d   = {bcd_d, {(iafmt_pkg::BUF_W - iafmt_pkg::BCD_W){1'b0}}};
          nd_d    = iafmt_pkg::CNT_W'(10);
          state_d = iafmt_pkg::ST_SKIP;
        end
      end
      iafmt_pkg::ST_SKIP: begin
        // Drop one leading zero digit per cycle, keeping at least one digit.
        if (nd_q > iafmt_pkg::CNT_W'(1) && top_dig == 4'd0) begin
          buf_d = buf_q << 4;
          nd_d  = nd_q - iafmt_pkg::CNT_W'(1);
        end else if (pre_cnt_q != '0) begin
          state_d = iafmt_pkg::ST_PRE;
        end else begin
          state_d = iafmt_pkg::ST_DIG;
        end
      end
      iafmt_pkg::ST_PRE: begin
        if (can_put) begin
          out_valid_d       = 1'b1;
          out_d.character   = pre_q[iafmt_pkg::PRE_W-1 -: 8];
          out_d.last        = (pre_cnt_q == iafmt_pkg::PRE_CNT_W'(1)) && (nd_q == '0);
          out_d.total_count = total_inc;
          total_d           = total_inc;
          pre_d             = pre_q << 8;
          pre_cnt_d         = pre_cnt_q - iafmt_pkg::PRE_CNT_W'(1);
          if (pre_cnt_q == iafmt_pkg::PRE_CNT_W'(1)) begin
            state_d = (nd_q != '0) ? iafmt_pkg::ST_DIG : iafmt_pkg::ST_IDLE;
          end
        end
      end
      iafmt_pkg::ST_DIG: begin
        if (can_put) begin
          out_valid_d       = 1'b1;
          out_d.character   = dig_char;
          out_d.last        = (nd_q == iafmt_pkg::CNT_W'(1));
          out_d.total_count = total_inc;
          total_d           = total_inc;
          buf_d             = buf_q << 4;
          nd_d              = nd_q - iafmt_pkg::CNT_W'(1);
          if (nd_q == iafmt_pkg::CNT_W'(1)) begin
            state_d = iafmt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = iafmt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iafmt_pkg::ST_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q     <= pre_d;
    pre_cnt_q <= pre_cnt_d;
    upper_q   <= upper_d;
    buf_q     <= buf_d;
    nd_q      <= nd_d;
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    step_q    <= step_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

### src/integer_to_ascii_formatter_core.sv
// A decimal word passes through the queue pop, the 32 shift-and-add-three steps, the start
// and the output load, plus the dropping of up to 9 leading zeros, before its first character.
// The back end starts the next word only after the last character of the current one is
// loaded into the output stage; hex and pointer words skip the decimal conversion.
// Reset (rst_ni low, asynchronous) empties the queue, clears the output stage
// and the character total, and sets the null pointer style to "(nil)".
// ----------------------------------------------------------------------------
// Integer to ASCII formatter core
// Prints signed and unsigned decimal, hex and pointer values as ASCII text.
// ----------------------------------------------------------------------------
//
// Structure
//   The front end decodes each accepted word into a job: an optional prefix
//   text (a minus sign, "0x", or the whole text for a null pointer) and a digit
//   job (decimal, 32-bit hex or 64-bit hex). Words with an unused mode are
//   accepted and produce no output. Jobs wait in a two-entry queue, so the
//   front end keeps taking words until it fills while the back end is busy or stalled.
//
//   The back end is a small sequencer. Decimal magnitudes go through a
//   32-step shift-and-add-three converter into ten BCD digits; hex digits are
//   taken straight from the value. Leading zero digits are then dropped, one
//   per cycle, always keeping the last digit so that zero prints as "0".
//   The prefix and the digits leave, unless stalled, one character per cycle
//   through a registered output stage, refilled in the same cycle that the
//   receiver takes the current word. The total count on each output word
//   includes that character and saturates at its all-ones value.
//
//   The null pointer style register may only be written while no word is in
//   flight.
module integer_to_ascii_formatter_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  iafmt_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output iafmt_pkg::out_word_t out_word_o
);

  iafmt_pkg::q_status_t q_status;
  iafmt_pkg::cmd_t      push_cmd;
  iafmt_pkg::cmd_t      head_cmd;
  logic                 push;
  logic                 pop;

  iafmt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  iafmt_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .head_o    (head_cmd),
    .status_o  (q_status)
  );

  iafmt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .head_i     (head_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

### test/integer_to_ascii_formatter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII formatter checker
// Watches the input, output and register ports of the formatter, predicts the
// text for every accepted word and compares each output word against it.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  iafmt_pkg::in_word_t  in_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  iafmt_pkg::out_word_t out_word_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam logic [iafmt_pkg::TOTAL_W-1:0] TOTAL_SAT = '1;
  localparam int REPORT_LIMIT = 10;

  iafmt_pkg::out_word_t          pending_chars [$];
  logic [iafmt_pkg::TOTAL_W-1:0] char_total;
  logic                          nil_as_hex;
  int                            chars_seen;

  task automatic queue_char(input logic [7:0] ch, input logic is_last);
    iafmt_pkg::out_word_t w;
    if (char_total != TOTAL_SAT) char_total++;
    w.character   = ch;
    w.last        = is_last;
    w.total_count = char_total;
    pending_chars.push_back(w);
  endtask

  // Builds the whole text of one word, then queues it with the last flag on
  // the final character.
  task automatic format_word(input iafmt_pkg::in_word_t w);
    logic [7:0]  txt [$];
    logic [3:0]  digits [$];
    logic [63:0] mag;
    logic [63:0] base;
    logic        upper;
    logic        with_digits;
    mag         = {32'd0, w.value[31:0]};
    base        = 64'd10;
    upper       = 1'b0;
    with_digits = 1'b1;
    case (w.mode)
      iafmt_pkg::MODE_SDEC: begin
        if (w.value[31]) begin
          txt.push_back(iafmt_pkg::CH_MINUS);
          mag[31:0] = ~w.value[31:0] + 32'd1;
        end
      end
      iafmt_pkg::MODE_UDEC: ;
      iafmt_pkg::MODE_HEX_L: base = 64'd16;
      iafmt_pkg::MODE_HEX_U: begin
        base  = 64'd16;
        upper = 1'b1;
      end
      iafmt_pkg::MODE_PTR: begin
        base = 64'd16;
        mag  = w.value;
        if (w.value == 64'd0) begin
          with_digits = 1'b0;
          if (nil_as_hex) begin
            txt.push_back(iafmt_pkg::CH_ZERO);
            txt.push_back(iafmt_pkg::CH_X);
            txt.push_back(iafmt_pkg::CH_ZERO);
          end else begin
            txt.push_back(iafmt_pkg::CH_LPAREN);
            txt.push_back(iafmt_pkg::CH_N);
            txt.push_back(iafmt_pkg::CH_I);
            txt.push_back(iafmt_pkg::CH_L);
            txt.push_back(iafmt_pkg::CH_RPAREN);
          end
        end else begin
          txt.push_back(iafmt_pkg::CH_ZERO);
          txt.push_back(iafmt_pkg::CH_X);
        end
      end
      default: with_digits = 1'b0;
    endcase
    if (with_digits) begin
      do begin
        digits.push_front(4'(mag % base));
        mag = mag / base;
      end while (mag != 64'd0);
      foreach (digits[i]) begin
        if (digits[i] < 4'd10) txt.push_back(iafmt_pkg::CH_ZERO + {4'd0, digits[i]});
        else txt.push_back((upper ? iafmt_pkg::CH_UPPER_A : iafmt_pkg::CH_LOWER_A) +
                           {4'd0, digits[i]} - 8'd10);
      end
    end
    foreach (txt[i]) queue_char(txt[i], i == txt.size() - 1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    iafmt_pkg::out_word_t exp_w;
    if (!rst_ni) begin
      pending_chars.delete();
      char_total   = '0;
      nil_as_hex   = 1'b0;
      chars_seen   = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_chars.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT)
            $display("unexpected output word %0d: char %h last %b total %0d", chars_seen,
                     out_word_i.character, out_word_i.last, out_word_i.total_count);
        end else begin
          exp_w = pending_chars.pop_front();
          if (out_word_i.character !== exp_w.character || out_word_i.last !== exp_w.last ||
              out_word_i.total_count !== exp_w.total_count) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT)
              $display({"mismatch on output word %0d: expected char %h last %b total %0d,",
                        " got char %h last %b total %0d"},
                       chars_seen, exp_w.character, exp_w.last, exp_w.total_count,
                       out_word_i.character, out_word_i.last, out_word_i.total_count);
          end
        end
        chars_seen++;
      end
      if (cfg_we_i) nil_as_hex = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) format_word(in_word_i);
      pending_o = pending_chars.size();
    end
  end

endmodule

### test/tb_integer_to_ascii_formatter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII formatter testbench
// Drives directed and random words through the formatter with random idle
// cycles on both sides and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter_core;

  // The slowest legal run is every word printing 18 characters, each held by
  // the longest receiver stall, plus the long hold-off and the sender gaps.
  // The limit is set well above that.
  localparam int LIMIT_CYCLES     = 1_500_000;
  localparam int SETTLE_CYCLES    = 80;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_PER_PHASE = 105;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic                 cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  iafmt_pkg::in_word_t  in_word;
  logic                 out_valid;
  logic                 out_stall;
  iafmt_pkg::out_word_t out_word;

  int        fail_count;
  int        chars_owed;
  int        cycle_count = 0;

  // Set by the stimulus process; the receiver process clears it once it has
  // held off for the full stretch.
  bit        hold_request = 1'b0;
  // While set, neither side inserts idle cycles.
  bit        no_idle      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  integer_to_ascii_formatter_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  integer_to_ascii_formatter_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (chars_owed)
  );

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Values are spread over all digit counts: full random words, shifted-down
  // words, single bits, tiny numbers, low words of all ones of any width, and zero.
  function automatic logic [63:0] pick_value();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0, 1: return raw;
      2:    return raw >> $urandom_range(0, 63);
      3:    return 64'd1 << $urandom_range(0, 63);
      4:    return 64'($urandom_range(0, 20));
      5:    return {raw[63:32], 32'hFFFF_FFFF >> $urandom_range(0, 31)};
      default: return 64'd0;
    endcase
  endfunction

  // Unused modes are accepted and print nothing, so they are kept rare.
  function automatic logic [2:0] pick_mode();
    if ($urandom_range(0, 99) < 6) return 3'($urandom_range(iafmt_pkg::MODE_PTR + 1, 7));
    return 3'($urandom_range(iafmt_pkg::MODE_SDEC, iafmt_pkg::MODE_PTR));
  endfunction

  // Offers one word, waits until it is taken and then for any gap. Valid stays
  // high when no gap follows, so back-to-back words never drop it.
  task automatic send_word(input logic [2:0] mode, input logic [63:0] value);
    int unsigned gap;
    in_valid      <= 1'b1;
    in_word.mode  <= mode;
    in_word.value <= value;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until the checker has seen every character owed.
  // The extra edge lets the checker take in the last accepted word first.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (chars_owed == 0);
  endtask

  // The register may only change with nothing in flight. A trailing word of an
  // unused mode owes nothing and is consumed at the input without being queued.
  task automatic write_nil_style(input logic style);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= style;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_word(pick_mode(), pick_value());
      // Now and then the sender waits for the block to empty completely.
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  // Receiver: alternates stretches of taking words with stretches of stalling,
  // and honors a long hold-off request so the block backs up to its input.
  initial begin
    int unsigned left;
    bit          stalling;
    left      = 0;
    stalling  = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_stall    <= 1'b0;
        left         = 0;
        stalling     = 1'b0;
      end else begin
        if (left == 0) begin
          stalling = !stalling && !no_idle;
          if (stalling) left = pick_gap() + 1;
          else if ($urandom_range(0, 9) == 0) left = $urandom_range(80, 200);
          else left = $urandom_range(1, 30);
        end
        out_stall <= stalling;
        left--;
      end
    end
  end

  // Run limit: a stuck handshake ends the run here.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words with the reset style, which prints a zero pointer as
    // "(nil)": zero, one, extremes of each width, the most negative signed
    // value, upper value bits that must be ignored, and every unused mode.
    send_word(iafmt_pkg::MODE_SDEC, 64'd0);
    send_word(iafmt_pkg::MODE_SDEC, 64'd1);
    send_word(iafmt_pkg::MODE_SDEC, 64'h0000_0000_FFFF_FFFF);
    send_word(iafmt_pkg::MODE_SDEC, 64'h0000_0000_8000_0000);
    send_word(iafmt_pkg::MODE_SDEC, 64'h0000_0000_7FFF_FFFF);
    send_word(iafmt_pkg::MODE_SDEC, 64'hFFFF_FFFF_0000_007B);
    send_word(iafmt_pkg::MODE_UDEC, 64'd0);
    send_word(iafmt_pkg::MODE_UDEC, 64'd9);
    send_word(iafmt_pkg::MODE_UDEC, 64'd10);
    send_word(iafmt_pkg::MODE_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(iafmt_pkg::MODE_HEX_L, 64'd0);
    send_word(iafmt_pkg::MODE_HEX_L, 64'h0000_0000_FFFF_FFFF);
    send_word(iafmt_pkg::MODE_HEX_L, 64'hAAAA_5555_DEAD_BEEF);
    send_word(iafmt_pkg::MODE_HEX_U, 64'd0);
    send_word(iafmt_pkg::MODE_HEX_U, 64'h0000_0000_ABCD_EF01);
    send_word(iafmt_pkg::MODE_PTR, 64'd0);
    send_word(iafmt_pkg::MODE_PTR, 64'd1);
    send_word(iafmt_pkg::MODE_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(iafmt_pkg::MODE_PTR, 64'h8000_0000_0000_0000);
    for (int m = iafmt_pkg::MODE_PTR + 1; m < 8; m++) send_word(3'(m), {$urandom, $urandom});

    // The other style prints a zero pointer as "0x0".
    write_nil_style(1'b1);
    send_word(iafmt_pkg::MODE_PTR, 64'd0);
    send_word(iafmt_pkg::MODE_PTR, 64'h0000_0000_0000_0010);
    send_word(iafmt_pkg::MODE_PTR, 64'd0);
    send_random(RANDOM_PER_PHASE);

    // Back to "(nil)", with a long receiver hold-off at the start so that the
    // job queue fills and the block stalls its input.
    write_nil_style(1'b0);
    hold_request = 1'b1;
    send_random(RANDOM_PER_PHASE);

    // A phase at full speed on both sides.
    write_nil_style(1'b1);
    no_idle = 1'b1;
    send_random(RANDOM_PER_PHASE);
    no_idle = 1'b0;

    write_nil_style(1'b0);
    send_random(RANDOM_PER_PHASE);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
src/iafmt_pkg.sv
src/iafmt_front.sv
src/iafmt_queue.sv
src/iafmt_back.sv
src/integer_to_ascii_formatter_core.sv
test/integer_to_ascii_formatter_checker.sv
test/tb_integer_to_ascii_formatter_core.sv
